/* rtl/ebh_pkg.sv */
// ----------------------------------------------------------------------------
// ebh_pkg
// Shared types and constants of the event histogram binner.
// ----------------------------------------------------------------------------
package ebh_pkg;

   localparam int STORE_AW    = 18;
   localparam int STORE_DEPTH = 2 ** STORE_AW;
   localparam int CNT_W       = 32;
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_COEF_XX      = 3'd0;
   localparam logic [2:0] REG_COEF_YX      = 3'd1;
   localparam logic [2:0] REG_OFFSET_X     = 3'd2;
   localparam logic [2:0] REG_COEF_XY      = 3'd3;
   localparam logic [2:0] REG_COEF_YY      = 3'd4;
   localparam logic [2:0] REG_OFFSET_Y     = 3'd5;
   localparam logic [2:0] REG_PLANE_ORIGIN = 3'd6;
   localparam logic [2:0] REG_PLANE_SCALE  = 3'd7;

   localparam logic [31:0] COEF_ONE = 32'h0100_0000;

   // request action codes
   localparam logic ACT_BIN  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic [31:0] coef_xx;
      logic [31:0] coef_yx;
      logic [31:0] offset_x;
      logic [31:0] coef_xy;
      logic [31:0] coef_yy;
      logic [31:0] offset_y;
      logic [31:0] plane_origin;
      logic [31:0] plane_scale;
   } cfg_type;

   typedef struct packed {
      logic                action;
      logic [31:0]         x_value;
      logic [31:0]         y_value;
      logic [31:0]         z_value;
      logic                keep;
      logic [STORE_AW-1:0] read_address;
   } item_type;

   typedef struct packed {
      logic en_mul;
      logic en_sum;
      logic en_bound;
      logic en_addr;
   } dp_ctrl_type;

   typedef struct packed {
      logic                hit;
      logic [STORE_AW-1:0] addr;
   } dp_result_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [CNT_W-1:0]    data;
   } store_wr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_BOUND,
      ST_ADDR,
      ST_FETCH,
      ST_DONE
   } state_type;

endpackage

/* rtl/ebh_if.sv */
// ----------------------------------------------------------------------------
// ebh_req_if / ebh_rsp_if
// Valid/ready channels for requests and results of the histogram binner.
// ----------------------------------------------------------------------------
interface ebh_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] x_value;
   logic [31:0] y_value;
   logic [31:0] z_value;
   logic        keep;
   logic [17:0] read_address;

   modport source (
      output valid, action, x_value, y_value, z_value, keep, read_address,
      input  ready
   );
   modport sink (
      input  valid, action, x_value, y_value, z_value, keep, read_address,
      output ready
   );
endinterface

interface ebh_rsp_if;
   logic        valid;
   logic        ready;
   logic        placed;
   logic [17:0] bin_address;
   logic [31:0] bin_count;

   modport source (
      output valid, placed, bin_address, bin_count,
      input  ready
   );
   modport sink (
      input  valid, placed, bin_address, bin_count,
      output ready
   );
endinterface

/* rtl/event_histogram_binner_unit.sv */
// ----------------------------------------------------------------------------
// event_histogram_binner_unit
// Bins events into a saturating counter histogram and reads single bins.
// ----------------------------------------------------------------------------
//  channel  | ports     | direction | carries
//  ---------+-----------+-----------+------------------------------------------
//  request  | req_if.*  | in        | action, x/y/z value, keep, read_address
//  result   | rsp_if.*  | out       | placed, bin_address, bin_count
//  config   | csr_*     | in/out    | APB-style, 8 x 32-bit registers at 4*i
//
//  A bin request walks from accept through the multiply, sum, bound and address
//  stages, then the counter memory read and the write back; the next request is
//  taken only after that. A read request goes through accept, memory read and
//  result. After reset a clearing pass writes zero to all 262144 counters, one
//  per cycle; no request is taken during the pass. A held result stalls the
//  sequencer in its last step until rsp_if.ready; the next request may be taken
//  while a result waits in the output register.
// ----------------------------------------------------------------------------
module event_histogram_binner_unit #(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256,
   parameter int GRID_DEPTH  = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   ebh_req_if.sink                    req_if,
   ebh_rsp_if.source                  rsp_if,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ebh_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ebh_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ebh_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int AW = ebh_pkg::STORE_AW;
   localparam int CW = ebh_pkg::CNT_W;

   ebh_pkg::cfg_type       cfg;
   ebh_pkg::item_type      item_ff, item_in;
   ebh_pkg::dp_ctrl_type   dp_ctrl;
   ebh_pkg::dp_result_type dp_res;
   ebh_pkg::store_wr_type  store_wr;
   ebh_pkg::state_type     state_ff, state_in;

   logic [AW-1:0] clear_addr_ff, clear_addr_in;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] rd_data;
   logic [CW-1:0] cnt_next;
   logic          slot_free;
   logic          rsp_load;
   logic          req_take;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_placed_ff, rsp_placed_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   ebh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ebh_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .GRID_DEPTH  (GRID_DEPTH)
   ) u_datapath (
      .clock (clock),
      .cfg   (cfg),
      .item  (item_ff),
      .ctrl  (dp_ctrl),
      .res   (dp_res)
   );

   ebh_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // the output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign req_take  = req_if.valid && req_if.ready;
   // saturate at all ones
   assign cnt_next  = (rd_data == '1) ? rd_data : rd_data + CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ebh_pkg::ST_CLEAR: begin
            if (clear_addr_ff == '1) state_in = ebh_pkg::ST_IDLE;
         end
         ebh_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               state_in = (req_if.action == ebh_pkg::ACT_READ) ? ebh_pkg::ST_FETCH
                                                               : ebh_pkg::ST_MUL;
            end
         end
         ebh_pkg::ST_MUL:   state_in = ebh_pkg::ST_SUM;
         ebh_pkg::ST_SUM:   state_in = ebh_pkg::ST_BOUND;
         ebh_pkg::ST_BOUND: state_in = ebh_pkg::ST_ADDR;
         ebh_pkg::ST_ADDR:  state_in = ebh_pkg::ST_FETCH;
         ebh_pkg::ST_FETCH: state_in = ebh_pkg::ST_DONE;
         ebh_pkg::ST_DONE: begin
            if (slot_free) state_in = ebh_pkg::ST_IDLE;
         end
         default: state_in = ebh_pkg::ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_if.ready     = (state_ff == ebh_pkg::ST_IDLE);
      dp_ctrl.en_mul   = (state_ff == ebh_pkg::ST_MUL);
      dp_ctrl.en_sum   = (state_ff == ebh_pkg::ST_SUM);
      dp_ctrl.en_bound = (state_ff == ebh_pkg::ST_BOUND);
      dp_ctrl.en_addr  = (state_ff == ebh_pkg::ST_ADDR);
      rd_en            = (state_ff == ebh_pkg::ST_FETCH);
      rd_addr          = (item_ff.action == ebh_pkg::ACT_READ) ? item_ff.read_address
                                                               : dp_res.addr;
      rsp_load         = (state_ff == ebh_pkg::ST_DONE) && slot_free;
      store_wr.en      = 1'b0;
      store_wr.addr    = dp_res.addr;
      store_wr.data    = cnt_next;
      if (state_ff == ebh_pkg::ST_CLEAR) begin
         store_wr.en   = 1'b1;
         store_wr.addr = clear_addr_ff;
         store_wr.data = '0;
      end else if (rsp_load && item_ff.action == ebh_pkg::ACT_BIN && dp_res.hit) begin
         // write back the incremented count
         store_wr.en   = 1'b1;
      end
   end

   // hold the request for the whole walk
   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.action       = req_if.action;
         item_in.x_value      = req_if.x_value;
         item_in.y_value      = req_if.y_value;
         item_in.z_value      = req_if.z_value;
         item_in.keep         = req_if.keep;
         item_in.read_address = req_if.read_address;
      end
   end

   always_comb begin
      clear_addr_in = clear_addr_ff;
      if (state_ff == ebh_pkg::ST_CLEAR) clear_addr_in = clear_addr_ff + AW'(1);
   end

   // result register: load on completion, drop on handshake
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_placed_in = rsp_placed_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_if.ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (item_ff.action == ebh_pkg::ACT_READ) begin
            rsp_placed_in = 1'b0;
            rsp_addr_in   = item_ff.read_address;
            rsp_count_in  = rd_data;
         end else if (dp_res.hit) begin
            rsp_placed_in = 1'b1;
            rsp_addr_in   = dp_res.addr;
            rsp_count_in  = cnt_next;
         end else begin
            rsp_placed_in = 1'b0;
            rsp_addr_in   = '0;
            rsp_count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ebh_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.placed      = rsp_placed_ff;
   assign rsp_if.bin_address = rsp_addr_ff;
   assign rsp_if.bin_count   = rsp_count_ff;

endmodule

/* rtl/ebh_csr.sv */
// ----------------------------------------------------------------------------
// ebh_csr
// APB-style configuration registers of the histogram binner.
// ----------------------------------------------------------------------------
module ebh_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ebh_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ebh_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ebh_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready,
   output ebh_pkg::cfg_type           cfg
);

   ebh_pkg::cfg_type cfg_ff;
   ebh_pkg::cfg_type cfg_in;
   logic [2:0]       index;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            ebh_pkg::REG_COEF_XX:      cfg_in.coef_xx      = csr_pwdata;
            ebh_pkg::REG_COEF_YX:      cfg_in.coef_yx      = csr_pwdata;
            ebh_pkg::REG_OFFSET_X:     cfg_in.offset_x     = csr_pwdata;
            ebh_pkg::REG_COEF_XY:      cfg_in.coef_xy      = csr_pwdata;
            ebh_pkg::REG_COEF_YY:      cfg_in.coef_yy      = csr_pwdata;
            ebh_pkg::REG_OFFSET_Y:     cfg_in.offset_y     = csr_pwdata;
            ebh_pkg::REG_PLANE_ORIGIN: cfg_in.plane_origin = csr_pwdata;
            ebh_pkg::REG_PLANE_SCALE:  cfg_in.plane_scale  = csr_pwdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ebh_pkg::REG_COEF_XX:      csr_prdata = cfg_ff.coef_xx;
         ebh_pkg::REG_COEF_YX:      csr_prdata = cfg_ff.coef_yx;
         ebh_pkg::REG_OFFSET_X:     csr_prdata = cfg_ff.offset_x;
         ebh_pkg::REG_COEF_XY:      csr_prdata = cfg_ff.coef_xy;
         ebh_pkg::REG_COEF_YY:      csr_prdata = cfg_ff.coef_yy;
         ebh_pkg::REG_OFFSET_Y:     csr_prdata = cfg_ff.offset_y;
         ebh_pkg::REG_PLANE_ORIGIN: csr_prdata = cfg_ff.plane_origin;
         ebh_pkg::REG_PLANE_SCALE:  csr_prdata = cfg_ff.plane_scale;
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{coef_xx:      ebh_pkg::COEF_ONE,
                     coef_yx:      32'h0,
                     offset_x:     32'h0,
                     coef_xy:      32'h0,
                     coef_yy:      ebh_pkg::COEF_ONE,
                     offset_y:     32'h0,
                     plane_origin: 32'h0,
                     plane_scale:  32'h0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/ebh_store.sv */
// ----------------------------------------------------------------------------
// ebh_store
// Counter memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ebh_store (
   input  logic                         clock,
   input  ebh_pkg::store_wr_type        wr,
   input  logic                         rd_en,
   input  logic [ebh_pkg::STORE_AW-1:0] rd_addr,
   output logic [ebh_pkg::CNT_W-1:0]    rd_data
);

   logic [ebh_pkg::CNT_W-1:0] mem [ebh_pkg::STORE_DEPTH];
   logic [ebh_pkg::CNT_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

/* rtl/ebh_datapath.sv */
// ----------------------------------------------------------------------------
// ebh_datapath
// Affine map, bounds check and bin address, four sequenced stages.
// ----------------------------------------------------------------------------
module ebh_datapath #(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256,
   parameter int GRID_DEPTH  = 4
) (
   input  logic                   clock,
   input  ebh_pkg::cfg_type       cfg,
   input  ebh_pkg::item_type      item,
   input  ebh_pkg::dp_ctrl_type   ctrl,
   output ebh_pkg::dp_result_type res
);

   localparam int XW = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
   localparam int YW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
   localparam int PW = (GRID_DEPTH  > 1) ? $clog2(GRID_DEPTH)  : 1;
   localparam int AW = ebh_pkg::STORE_AW;
   localparam logic [AW-1:0] ROW_STRIDE   = AW'(GRID_WIDTH);
   localparam logic [AW-1:0] PLANE_STRIDE = AW'(GRID_WIDTH * GRID_HEIGHT);

   // multiply stage
   logic signed [63:0] prod_xx_ff, prod_yx_ff, prod_xy_ff, prod_yy_ff;
   logic signed [63:0] prod_xx_in, prod_yx_in, prod_xy_in, prod_yy_in;
   logic signed [32:0] diff_ff, diff_in;
   // sum stage
   logic signed [65:0] sum_x_ff, sum_y_ff, sum_x_in, sum_y_in;
   logic [64:0]        plane_prod_ff, plane_prod_in;
   logic               neg_ff;
   // bound stage
   logic [XW-1:0]      gx_ff;
   logic [YW-1:0]      gy_ff;
   logic [PW-1:0]      plane_ff;
   logic               hit_ff, hit_in;
   logic [25:0]        gx, gy;
   logic [32:0]        plane_full;
   logic               gx_ok, gy_ok, plane_ok;
   // address stage
   logic [AW-1:0]      addr_ff, addr_in;

   always_comb begin
      prod_xx_in = 64'($signed(item.x_value)) * 64'($signed(cfg.coef_xx));
      prod_yx_in = 64'($signed(item.y_value)) * 64'($signed(cfg.coef_yx));
      prod_xy_in = 64'($signed(item.x_value)) * 64'($signed(cfg.coef_xy));
      prod_yy_in = 64'($signed(item.y_value)) * 64'($signed(cfg.coef_yy));
      diff_in    = 33'($signed(item.z_value)) - 33'($signed(cfg.plane_origin));
   end

   always_comb begin
      sum_x_in = 66'(prod_xx_ff) + 66'(prod_yx_ff)
               + (66'($signed(cfg.offset_x)) <<< 24);
      sum_y_in = 66'(prod_xy_ff) + 66'(prod_yy_ff)
               + (66'($signed(cfg.offset_y)) <<< 24);
      // plane = floor(d * scale / 2^32); only meaningful for d >= 0
      plane_prod_in = 65'($unsigned(diff_ff)) * 65'(cfg.plane_scale);
   end

   always_comb begin
      // floor of the Q.40 sum is an arithmetic shift
      gx         = sum_x_ff[65:40];
      gy         = sum_y_ff[65:40];
      plane_full = plane_prod_ff[64:32];
      gx_ok      = !gx[25] && (gx < 26'(GRID_WIDTH));
      gy_ok      = !gy[25] && (gy < 26'(GRID_HEIGHT));
      if (cfg.plane_scale == '0) begin
         plane_ok = 1'b1;
      end else begin
         plane_ok = !neg_ff && (plane_full < 33'(GRID_DEPTH));
      end
      hit_in = item.keep && gx_ok && gy_ok && plane_ok;
   end

   always_comb begin
      addr_in = (AW'(plane_ff) * PLANE_STRIDE) + (AW'(gy_ff) * ROW_STRIDE) + AW'(gx_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en_mul) begin
         prod_xx_ff <= prod_xx_in;
         prod_yx_ff <= prod_yx_in;
         prod_xy_ff <= prod_xy_in;
         prod_yy_ff <= prod_yy_in;
         diff_ff    <= diff_in;
      end
      if (ctrl.en_sum) begin
         sum_x_ff      <= sum_x_in;
         sum_y_ff      <= sum_y_in;
         plane_prod_ff <= plane_prod_in;
         neg_ff        <= diff_ff[32];
      end
      if (ctrl.en_bound) begin
         gx_ff    <= gx[XW-1:0];
         gy_ff    <= gy[YW-1:0];
         plane_ff <= (cfg.plane_scale == '0) ? '0 : plane_full[PW-1:0];
         hit_ff   <= hit_in;
      end
      if (ctrl.en_addr) begin
         addr_ff <= addr_in;
      end
   end

   assign res.hit  = hit_ff;
   assign res.addr = addr_ff;

endmodule

/* tb/tb.sv */
// ============================================================================
// tb - event_histogram_binner_unit testbench
// Streams bin and read requests through the binner under three register
// settings and checks every result against an in-bench model of the affine
// map, the plane selection and the saturating counter store.
// ============================================================================
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;
   localparam int GRID_DEPTH  = 4;

   // The clearing pass after reset keeps both channels quiet for a whole store
   // sweep; that is by far the longest legal gap, so size the watchdog on it.
   localparam int IDLE_LIMIT  = 4 * ebh_pkg::STORE_DEPTH + 20000;
   localparam int HOLD_CYCLES = 150;
   localparam int MAX_REPORTS = 10;

   // register settings the run walks through
   localparam int SET_IDENTITY = 0;
   localparam int SET_WARPED   = 1;
   localparam int SET_EXTREME  = 2;

   typedef struct packed {
      logic                         placed;
      logic [ebh_pkg::STORE_AW-1:0] bin_address;
      logic [ebh_pkg::CNT_W-1:0]    bin_count;
   } bin_outcome_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [ebh_pkg::CSR_AW-1:0] csr_paddr;
   logic [ebh_pkg::CSR_DW-1:0] csr_pwdata;
   logic [ebh_pkg::CSR_DW-1:0] csr_prdata;
   logic                       csr_pready;

   ebh_req_if req_ch ();
   ebh_rsp_if rsp_ch ();

   event_histogram_binner_unit #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .GRID_DEPTH  (GRID_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // -------------------------------------------------------------------------
   // Model state: a copy of the registers and of the counter store. The store
   // starts at zero, which is what the clearing pass leaves behind.
   // -------------------------------------------------------------------------
   ebh_pkg::cfg_type             binner_cfg;
   bit [ebh_pkg::CNT_W-1:0]      bin_counts [ebh_pkg::STORE_DEPTH];
   logic [ebh_pkg::STORE_AW-1:0] touched_bins [$];

   ebh_pkg::item_type            queued_requests [$];
   bin_outcome_type              expected_bins [$];

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_rsp;
   bit  stress_armed;
   bit  req_taken;
   int  idle_cycles;
   int  fault_count;
   int  requests_taken;
   int  placed_seen;
   int  rejected_seen;
   int  reads_seen;

   // floor((a*ca + b*cb) / 2^40 + off / 2^16), exact: 66 bits hold the sum of
   // two 64-bit products and the scaled offset without wrapping
   function automatic logic signed [25:0] grid_coord(input logic signed [31:0] a,
                                                     input logic signed [31:0] ca,
                                                     input logic signed [31:0] b,
                                                     input logic signed [31:0] cb,
                                                     input logic signed [31:0] off);
      logic signed [65:0] wa, wca, wb, wcb, woff, acc;
      wa   = a;
      wca  = ca;
      wb   = b;
      wcb  = cb;
      woff = off;
      acc  = wa * wca + wb * wcb + woff * 66'sd16777216;
      return $signed(acc[65:40]);
   endfunction

   // Predict the result of one accepted request and advance the model store.
   function automatic bin_outcome_type tally_request(input ebh_pkg::item_type it);
      bin_outcome_type           res;
      logic signed [25:0]        gx, gy;
      logic signed [32:0]        dz;
      logic [65:0]               prod;
      logic [33:0]               plane;
      logic [63:0]               lin;
      logic [ebh_pkg::CNT_W-1:0] cnt;
      res = '0;
      if (it.action == ebh_pkg::ACT_READ) begin
         res.bin_address = it.read_address;
         res.bin_count   = bin_counts[it.read_address];
         reads_seen++;
         return res;
      end
      if (!it.keep) begin
         rejected_seen++;
         return res;
      end
      gx = grid_coord(it.x_value, binner_cfg.coef_xx, it.y_value, binner_cfg.coef_yx,
                      binner_cfg.offset_x);
      gy = grid_coord(it.x_value, binner_cfg.coef_xy, it.y_value, binner_cfg.coef_yy,
                      binner_cfg.offset_y);
      if (gx < 0 || gx >= GRID_WIDTH || gy < 0 || gy >= GRID_HEIGHT) begin
         rejected_seen++;
         return res;
      end
      plane = '0;
      if (binner_cfg.plane_scale != '0) begin
         // z below the origin floors to a negative plane
         dz = $signed({it.z_value[31], it.z_value})
            - $signed({binner_cfg.plane_origin[31], binner_cfg.plane_origin});
         if (dz < 0) begin
            rejected_seen++;
            return res;
         end
         prod  = 66'(dz[32:0]) * 66'(binner_cfg.plane_scale);
         plane = prod[65:32];
         if (plane >= GRID_DEPTH) begin
            rejected_seen++;
            return res;
         end
      end
      lin = 64'(plane) * GRID_WIDTH * GRID_HEIGHT
          + 64'($unsigned(gy)) * GRID_WIDTH + 64'($unsigned(gx));
      cnt = bin_counts[lin[ebh_pkg::STORE_AW-1:0]];
      if (cnt != '1) cnt++;
      bin_counts[lin[ebh_pkg::STORE_AW-1:0]] = cnt;
      touched_bins.push_back(lin[ebh_pkg::STORE_AW-1:0]);
      placed_seen++;
      res.placed      = 1'b1;
      res.bin_address = lin[ebh_pkg::STORE_AW-1:0];
      res.bin_count   = cnt;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Request builders
   // -------------------------------------------------------------------------
   function automatic ebh_pkg::item_type event_req(input logic [31:0] x,
                                                   input logic [31:0] y,
                                                   input logic [31:0] z,
                                                   input logic keep);
      ebh_pkg::item_type it;
      it.action       = ebh_pkg::ACT_BIN;
      it.x_value      = x;
      it.y_value      = y;
      it.z_value      = z;
      it.keep         = keep;
      it.read_address = ebh_pkg::STORE_AW'($urandom);
      return it;
   endfunction

   // unused fields of a read carry noise; the block must ignore them
   function automatic ebh_pkg::item_type read_req(input logic [ebh_pkg::STORE_AW-1:0] addr);
      ebh_pkg::item_type it;
      it.action       = ebh_pkg::ACT_READ;
      it.x_value      = $urandom;
      it.y_value      = $urandom;
      it.z_value      = $urandom;
      it.keep         = 1'($urandom_range(0, 1));
      it.read_address = addr;
      return it;
   endfunction

   // Mostly events aimed at the grid for the active setting (two in seven of them
   // at a small hot spot so counters climb), plus reads and raw noise.
   function automatic ebh_pkg::item_type random_request(input int setting);
      ebh_pkg::item_type it;
      int unsigned       roll;
      int unsigned       span;
      bit                hot;
      it   = event_req($urandom, $urandom, $urandom, 1'b1);
      roll = $urandom_range(0, 99);
      hot  = (roll >= 80);
      if (roll < 15) begin
         it = read_req(ebh_pkg::STORE_AW'($urandom));
         if (roll < 10 && touched_bins.size() != 0)
            it.read_address = touched_bins[$urandom_range(0, touched_bins.size() - 1)];
      end else if (roll < 30) begin
         it.keep = 1'($urandom_range(0, 1));
      end else begin
         it.keep = ($urandom_range(0, 15) != 0);
         case (setting)
            SET_IDENTITY: begin
               span       = hot ? 4 * 65536 : 256 * 65536;
               it.x_value = $urandom_range(0, span - 1);
               it.y_value = $urandom_range(0, span - 1);
            end
            SET_WARPED: begin
               // x, y in [0, 256) stay on the grid; z spans a bit below the
               // origin up to past the last plane
               span       = hot ? 8 * 65536 : 256 * 65536;
               it.x_value = $urandom_range(0, span - 1);
               it.y_value = $urandom_range(0, span - 1);
               it.z_value = 32'($urandom_range(0, 262144)) - 32'd262144;
            end
            default: begin
               // only a thin band near y = 255, x - y = 256 lands on the grid,
               // and z must sit within a few LSBs of the most negative origin
               it.y_value = 32'h00FF_0000 + $urandom_range(0, 65535);
               it.x_value = it.y_value + 32'h0100_0000
                          + $urandom_range(0, hot ? 4095 : 131071);
               it.z_value = 32'h8000_0000 + $urandom_range(0, 5);
            end
         endcase
      end
      return it;
   endfunction

   function automatic ebh_pkg::cfg_type setting_regs(input int setting);
      ebh_pkg::cfg_type c;
      case (setting)
         SET_IDENTITY: begin
            c = '{coef_xx: ebh_pkg::COEF_ONE, coef_yx: 32'h0, offset_x: 32'h0,
                  coef_xy: 32'h0, coef_yy: ebh_pkg::COEF_ONE, offset_y: 32'h0,
                  plane_origin: 32'h0, plane_scale: 32'h0};
         end
         SET_WARPED: begin
            // X = 0.5x - 0.25y + 64, Y = 0.25x + 0.5y + 16, 1.5 planes per
            // unit of z starting at -3.0
            c = '{coef_xx: 32'h0080_0000, coef_yx: 32'hFFC0_0000, offset_x: 32'h0040_0000,
                  coef_xy: 32'h0040_0000, coef_yy: 32'h0080_0000, offset_y: 32'h0010_0000,
                  plane_origin: 32'hFFFD_0000, plane_scale: 32'h0001_8000};
         end
         default: begin
            c = '{coef_xx: 32'h7FFF_FFFF, coef_yx: 32'h8000_0000, offset_x: 32'h8000_0000,
                  coef_xy: 32'h0000_0000, coef_yy: 32'h8000_0000, offset_y: 32'h7FFF_FFFF,
                  plane_origin: 32'h8000_0000, plane_scale: 32'hFFFF_FFFF};
         end
      endcase
      return c;
   endfunction

   // -------------------------------------------------------------------------
   // Register port: setup cycle, access cycle, then release
   // -------------------------------------------------------------------------
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         ebh_pkg::REG_COEF_XX:      binner_cfg.coef_xx      = val;
         ebh_pkg::REG_COEF_YX:      binner_cfg.coef_yx      = val;
         ebh_pkg::REG_OFFSET_X:     binner_cfg.offset_x     = val;
         ebh_pkg::REG_COEF_XY:      binner_cfg.coef_xy      = val;
         ebh_pkg::REG_COEF_YY:      binner_cfg.coef_yy      = val;
         ebh_pkg::REG_OFFSET_Y:     binner_cfg.offset_y     = val;
         ebh_pkg::REG_PLANE_ORIGIN: binner_cfg.plane_origin = val;
         default:                   binner_cfg.plane_scale  = val;
      endcase
   endtask

   task automatic program_csr(input ebh_pkg::cfg_type c);
      csr_write(ebh_pkg::REG_COEF_XX,      c.coef_xx);
      csr_write(ebh_pkg::REG_COEF_YX,      c.coef_yx);
      csr_write(ebh_pkg::REG_OFFSET_X,     c.offset_x);
      csr_write(ebh_pkg::REG_COEF_XY,      c.coef_xy);
      csr_write(ebh_pkg::REG_COEF_YY,      c.coef_yy);
      csr_write(ebh_pkg::REG_OFFSET_Y,     c.offset_y);
      csr_write(ebh_pkg::REG_PLANE_ORIGIN, c.plane_origin);
      csr_write(ebh_pkg::REG_PLANE_SCALE,  c.plane_scale);
   endtask

   // Hold until every queued request went out and every result came back.
   // A request accepted at this edge still shows valid high, so its
   // expectation is always pushed before the queue is seen empty.
   task automatic wait_all_results();
      do @(posedge clock);
      while (queued_requests.size() != 0 || req_ch.valid || expected_bins.size() != 0);
      // let the sequencer settle before touching registers
      repeat (8) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Clock and known values on every input from time zero
   // -------------------------------------------------------------------------
   initial begin : clock_gen
      clock                = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.action        = ebh_pkg::ACT_BIN;
      req_ch.x_value       = '0;
      req_ch.y_value       = '0;
      req_ch.z_value       = '0;
      req_ch.keep          = 1'b0;
      req_ch.read_address  = '0;
      rsp_ch.ready         = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Request driver: advance at the falling edge once the current request was
   // taken (or none is up); otherwise hold valid and payload steady.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      ebh_pkg::item_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         req_taken = 1'b0;
         if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            it = queued_requests.pop_front();
            req_ch.action       <= it.action;
            req_ch.x_value      <= it.x_value;
            req_ch.y_value      <= it.y_value;
            req_ch.z_value      <= it.z_value;
            req_ch.keep         <= it.keep;
            req_ch.read_address <= it.read_address;
            req_ch.valid        <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, plus the long hold-off when it is on
   always @(negedge clock) begin : rsp_receiver
      rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Long receiver hold-off during the busy last setting: the sender keeps
   // offering, so the output register and the sequencer fill up and the
   // request side has to stall.
   initial begin : rsp_holdoff
      hold_rsp = 1'b0;
      do @(posedge clock); while (!(stress_armed && queued_requests.size() <= 200));
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge. An accepted request
   // is run through the model right away; each accepted result is checked
   // against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      ebh_pkg::item_type seen;
      bin_outcome_type   got, want;
      if (!reset && req_ch.valid && req_ch.ready) begin
         seen.action       = req_ch.action;
         seen.x_value      = req_ch.x_value;
         seen.y_value      = req_ch.y_value;
         seen.z_value      = req_ch.z_value;
         seen.keep         = req_ch.keep;
         seen.read_address = req_ch.read_address;
         expected_bins.push_back(tally_request(seen));
         req_taken = 1'b1;
         requests_taken++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.placed      = rsp_ch.placed;
         got.bin_address = rsp_ch.bin_address;
         got.bin_count   = rsp_ch.bin_count;
         if (expected_bins.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("%0t: unexpected result placed=%0d addr=%0d count=%0d", $realtime,
                        got.placed, got.bin_address, got.bin_count);
         end else begin
            want = expected_bins.pop_front();
            if (got != want) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("%0t: result mismatch, expected placed=%0d addr=%0d count=%0d,%s",
                           $realtime, want.placed, want.bin_address, want.bin_count,
                           $sformatf(" got placed=%0d addr=%0d count=%0d",
                                     got.placed, got.bin_address, got.bin_count));
            end
         end
      end
   end

   // watchdog: any handshake on either channel counts as progress
   always @(posedge clock) begin : watchdog
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("no request or result moved for %0d cycles", idle_cycles);
         $display("event_histogram_binner_unit test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence of the run
   // -------------------------------------------------------------------------
   initial begin : stimulus
      send_idle_pct = 38;
      recv_idle_pct = 80;
      stress_armed  = 1'b0;
      binner_cfg    = setting_regs(SET_IDENTITY);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- identity map, no third column; sender idles lightly, receiver a lot
      program_csr(setting_regs(SET_IDENTITY));
      queued_requests.push_back(read_req(18'd0));
      queued_requests.push_back(read_req(18'h3FFFF));
      // first bin, then again from inside the same cell
      queued_requests.push_back(event_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
      queued_requests.push_back(event_req(32'h0000_FFFF, 32'h0000_FFFF, 32'h7FFF_FFFF, 1'b1));
      // last cell of the grid
      queued_requests.push_back(event_req(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h8000_0000, 1'b1));
      // one step past each edge of the grid
      queued_requests.push_back(event_req(32'h0100_0000, 32'h0000_0000, 32'h0, 1'b1));
      queued_requests.push_back(event_req(32'h0000_0000, 32'h0100_0000, 32'h0, 1'b1));
      queued_requests.push_back(event_req(32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 1'b1));
      queued_requests.push_back(event_req(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 1'b1));
      // extreme coordinates
      queued_requests.push_back(event_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1));
      queued_requests.push_back(event_req(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
      // filtered out by the row filter, then the same event kept
      queued_requests.push_back(event_req(32'h0005_0000, 32'h0003_0000, 32'h0, 1'b0));
      queued_requests.push_back(event_req(32'h0005_0000, 32'h0003_0000, 32'h0, 1'b1));
      queued_requests.push_back(read_req(18'd0));
      queued_requests.push_back(read_req(18'(GRID_WIDTH * GRID_HEIGHT - 1)));
      queued_requests.push_back(read_req(18'(3 * GRID_WIDTH + 5)));
      queued_requests.push_back(read_req(18'(3 * GRID_WIDTH + 6)));
      for (int n = 0; n < 320; n++)
         queued_requests.push_back(random_request(SET_IDENTITY));
      wait_all_results();

      // --- warped map with planes; idling swapped between the two sides
      send_idle_pct = 80;
      recv_idle_pct = 38;
      program_csr(setting_regs(SET_WARPED));
      // z one LSB below the origin, at the origin, at the top of the last
      // plane and one LSB past it
      queued_requests.push_back(event_req(32'h0001_0000, 32'h0001_0000, 32'hFFFC_FFFF, 1'b1));
      queued_requests.push_back(event_req(32'h0001_0000, 32'h0001_0000, 32'hFFFD_0000, 1'b1));
      queued_requests.push_back(event_req(32'h0001_0000, 32'h0001_0000, 32'hFFFF_AAAA, 1'b1));
      queued_requests.push_back(event_req(32'h0001_0000, 32'h0001_0000, 32'hFFFF_AAAB, 1'b1));
      queued_requests.push_back(read_req(18'(3 * GRID_WIDTH * GRID_HEIGHT
                                              + 16 * GRID_WIDTH + 64)));
      for (int n = 0; n < 320; n++)
         queued_requests.push_back(random_request(SET_WARPED));
      wait_all_results();

      // --- extreme registers, no idling on either side, long hold-off inside
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_csr(setting_regs(SET_EXTREME));
      for (int n = 0; n < 310; n++)
         queued_requests.push_back(random_request(SET_EXTREME));
      stress_armed = 1'b1;
      wait_all_results();

      repeat (20) @(posedge clock);
      fault_count += expected_bins.size();

      $display("covered %0d requests over three register settings: %0d events binned,",
               requests_taken, placed_seen);
      $display("%0d events rejected, %0d bins read back; %0d failures",
               rejected_seen, reads_seen, fault_count);
      if (fault_count == 0) begin
         $display("event_histogram_binner_unit test passed");
      end else begin
         $display("event_histogram_binner_unit test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/ebh_pkg.sv
rtl/ebh_if.sv
rtl/ebh_csr.sv
rtl/ebh_store.sv
rtl/ebh_datapath.sv
rtl/event_histogram_binner_unit.sv
tb/tb.sv
